FILE: design/tfs_pkg.sv
// ----------------------------------------------------------------------------
// Three-level feedback scheduler package
// Shared types, codes and constants of the controller and the datapath.
// ----------------------------------------------------------------------------
package tfs_pkg;

  localparam int unsigned BUDGET_W = 10;
  localparam int unsigned AGE_W    = 9;
  localparam int unsigned OUT_ID_W = 6;
  localparam int unsigned SLICE_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 10'd300;
  localparam logic [AGE_W-1:0]    AGE_RESET    = 9'd375;

  localparam logic [SLICE_W-1:0] SLICE_L0 = 7'd25;
  localparam logic [SLICE_W-1:0] SLICE_L1 = 7'd50;
  localparam logic [SLICE_W-1:0] SLICE_L2 = 7'd100;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ID = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT    = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CREATE,
    OP_START,
    OP_CHG_RD,
    OP_CHG_WR,
    OP_RF_INIT,
    OP_WALK,
    OP_WALK_NX,
    OP_MOVE,
    OP_MOVE_NX,
    OP_OUT_RD,
    OP_OUT_WR,
    OP_EMIT
  } dp_op_e;

  // Refill counting passes, in the order they run.
  typedef enum logic [2:0] {
    PH_2A,
    PH_1A,
    PH_0,
    PH_1B,
    PH_2B
  } walk_ph_e;

  typedef struct packed {
    dp_op_e     op;
    walk_ph_e   ph;
    logic [1:0] lvl;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic started;
    logic run_empty;
    logic walk_go;
    logic move_go;
  } dp_sts_t;

  function automatic logic [1:0] clamp_level(input logic [1:0] lvl);
    return (lvl > 2'd2) ? 2'd2 : lvl;
  endfunction

  function automatic logic [SLICE_W-1:0] charge_of(input logic [1:0] lvl);
    logic [SLICE_W-1:0] c;
    case (clamp_level(lvl))
      2'd2:    c = SLICE_L2;
      2'd1:    c = SLICE_L1;
      default: c = SLICE_L0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] ph_level(input walk_ph_e ph);
    logic [1:0] l;
    case (ph)
      PH_2A, PH_2B: l = 2'd2;
      PH_1A, PH_1B: l = 2'd1;
      default:      l = 2'd0;
    endcase
    return l;
  endfunction

endpackage

FILE: design/tfs_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences create, start, charge, refill walk, refill move and result hand-off.
// ----------------------------------------------------------------------------
module tfs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tfs_pkg::dp_cmd_t cmd_o,
  input  tfs_pkg::dp_sts_t sts_i
);
  import tfs_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DISP    = 15'b000000000000010,
    S_CREATE  = 15'b000000000000100,
    S_START   = 15'b000000000001000,
    S_CHG_RD  = 15'b000000000010000,
    S_CHG_WR  = 15'b000000000100000,
    S_POST    = 15'b000000001000000,
    S_RF_INIT = 15'b000000010000000,
    S_WALK    = 15'b000000100000000,
    S_WALK_NX = 15'b000001000000000,
    S_MOVE    = 15'b000010000000000,
    S_MOVE_NX = 15'b000100000000000,
    S_OUT_RD  = 15'b001000000000000,
    S_OUT_WR  = 15'b010000000000000,
    S_EMIT    = 15'b100000000000000
  } state_e;

  state_e     state_q, state_d;
  walk_ph_e   phase_q, phase_d;
  logic [1:0] mv_lvl_q, mv_lvl_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    mv_lvl_d    = mv_lvl_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.ph    = phase_q;
    cmd_o.lvl   = mv_lvl_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts_i.mode) begin
          state_d = S_CREATE;
        end else if (!sts_i.started) begin
          state_d = S_START;
        end else if (!sts_i.run_empty) begin
          state_d = S_CHG_RD;
        end else begin
          state_d = S_RF_INIT;
        end
      end
      S_CREATE: begin
        cmd_o.op = OP_CREATE;
        state_d  = S_EMIT;
      end
      S_START: begin
        cmd_o.op = OP_START;
        state_d  = S_RF_INIT;
      end
      S_CHG_RD: begin
        cmd_o.op = OP_CHG_RD;
        state_d  = S_CHG_WR;
      end
      S_CHG_WR: begin
        cmd_o.op = OP_CHG_WR;
        state_d  = S_POST;
      end
      S_POST: begin
        state_d = sts_i.run_empty ? S_RF_INIT : S_OUT_RD;
      end
      S_RF_INIT: begin
        cmd_o.op = OP_RF_INIT;
        phase_d  = PH_2A;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_go) begin
          cmd_o.op = OP_WALK;
          state_d  = S_WALK_NX;
        end else begin
          case (phase_q)
            PH_2A:   phase_d = PH_1A;
            PH_1A:   phase_d = PH_0;
            PH_0:    phase_d = PH_1B;
            PH_1B:   phase_d = PH_2B;
            default: begin
              mv_lvl_d = 2'd0;
              state_d  = S_MOVE;
            end
          endcase
        end
      end
      S_WALK_NX: begin
        cmd_o.op = OP_WALK_NX;
        state_d  = S_WALK;
      end
      S_MOVE: begin
        if (sts_i.move_go) begin
          cmd_o.op = OP_MOVE;
          state_d  = S_MOVE_NX;
        end else if (mv_lvl_q == 2'd2) begin
          state_d = S_OUT_RD;
        end else begin
          mv_lvl_d = mv_lvl_q + 2'd1;
        end
      end
      S_MOVE_NX: begin
        cmd_o.op = OP_MOVE_NX;
        state_d  = S_MOVE;
      end
      S_OUT_RD: begin
        cmd_o.op = OP_OUT_RD;
        state_d  = S_OUT_WR;
      end
      S_OUT_WR: begin
        cmd_o.op = OP_OUT_WR;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_2A;
      mv_lvl_q    <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      mv_lvl_q    <= mv_lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/tfs_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Per-thread link, level and run-time memories, queue pointers, refill
// counters, configuration registers and the result registers.
// ----------------------------------------------------------------------------
module tfs_datapath #(
  parameter int unsigned MAX_THREADS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tfs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              mode_i,
  input  logic                              whole_slice_i,
  input  logic                              exited_i,
  input  tfs_pkg::dp_cmd_t                  cmd_i,
  output tfs_pkg::dp_sts_t                  sts_o,
  output logic [tfs_pkg::OUT_ID_W-1:0]      next_thread_o,
  output logic [tfs_pkg::SLICE_W-1:0]       slice_ms_o,
  output logic [tfs_pkg::OUT_ID_W-1:0]      new_thread_o,
  output logic [tfs_pkg::STATUS_W-1:0]      status_o
);
  import tfs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_THREADS);
  localparam logic [IW:0] ID_LIMIT = (IW+1)'(MAX_THREADS);

  // Thread stores; entries are written before any read that matters.
  logic [IW-1:0]    link_mem [MAX_THREADS];
  logic [1:0]       lvl_mem  [MAX_THREADS];
  logic [AGE_W-1:0] time_mem [MAX_THREADS];

  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    link_rd_q;
  logic [1:0]       lvl_rd_q;
  logic [AGE_W-1:0] time_rd_q;

  logic             link_we;
  logic [IW-1:0]    link_waddr, link_wdata;
  logic             lvl_we, time_we;
  logic [IW-1:0]    wr_addr;
  logic [1:0]       lvl_wdata;
  logic [AGE_W-1:0] time_wdata;

  logic [BUDGET_W-1:0] budget_q;
  logic [AGE_W-1:0]    age_q;

  logic          started_q, started_d;
  logic [IW:0]   next_id_q, next_id_d;
  logic [IW-1:0] run_head_q, run_head_d, run_tail_q, run_tail_d;
  logic [IW-1:0] head_q [3];
  logic [IW-1:0] head_d [3];
  logic [IW-1:0] tail_q [3];
  logic [IW-1:0] tail_d [3];
  logic [IW-1:0] cur_q [3];
  logic [IW-1:0] cur_d [3];
  logic [IW-1:0] n_q [3];
  logic [IW-1:0] n_d [3];
  logic [COUNT_W-1:0] count_q, count_d;
  logic mode_q, mode_d, whole_q, whole_d, exited_q, exited_d;

  logic [OUT_ID_W-1:0] res_next_q, res_next_d, res_new_q, res_new_d;
  logic [SLICE_W-1:0]  res_slice_q, res_slice_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;
  logic [OUT_ID_W-1:0] out_next_q, out_next_d, out_new_q, out_new_d;
  logic [SLICE_W-1:0]  out_slice_q, out_slice_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;

  logic [1:0]         wl;
  logic [1:0]         ml;
  logic [COUNT_W-1:0] budget_x;
  logic               walk_go;

  assign wl       = ph_level(cmd_i.ph);
  assign ml       = cmd_i.lvl;
  assign budget_x = COUNT_W'(budget_q);

  always_comb begin
    logic [IW-1:0] c;
    c = cur_q[wl];
    case (cmd_i.ph)
      PH_2A:   walk_go = (c != '0) && (n_q[2] == '0);
      PH_1A:   walk_go = (c != '0) && (n_q[1] < IW'(2));
      default: walk_go = (c != '0) && (count_q < budget_x);
    endcase
  end

  assign sts_o.mode      = mode_q;
  assign sts_o.started   = started_q;
  assign sts_o.run_empty = (run_head_q == '0);
  assign sts_o.walk_go   = walk_go;
  assign sts_o.move_go   = (n_q[ml] != '0) && (head_q[ml] != '0);

  always_comb begin
    logic [IW-1:0]      id;
    logic [IW-1:0]      nxt;
    logic [1:0]         lc;
    logic [1:0]         nl;
    logic [AGE_W:0]     tsum;
    logic               aged;
    started_d   = started_q;
    next_id_d   = next_id_q;
    run_head_d  = run_head_q;
    run_tail_d  = run_tail_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    n_d         = n_q;
    count_d     = count_q;
    mode_d      = mode_q;
    whole_d     = whole_q;
    exited_d    = exited_q;
    res_next_d  = res_next_q;
    res_new_d   = res_new_q;
    res_slice_d = res_slice_q;
    res_st_d    = res_st_q;
    out_next_d  = out_next_q;
    out_new_d   = out_new_q;
    out_slice_d = out_slice_q;
    out_st_d    = out_st_q;
    rd_addr     = run_head_q;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = '0;
    lvl_we      = 1'b0;
    time_we     = 1'b0;
    wr_addr     = '0;
    lvl_wdata   = 2'd0;
    time_wdata  = '0;
    id          = '0;
    nxt         = '0;
    lc          = clamp_level(lvl_rd_q);
    nl          = 2'd0;
    tsum        = (AGE_W+1)'(time_rd_q) + (AGE_W+1)'(charge_of(lc));
    aged        = (tsum >= (AGE_W+1)'(age_q));
    case (cmd_i.op)
      OP_LATCH: begin
        mode_d   = mode_i;
        whole_d  = whole_slice_i;
        exited_d = exited_i;
      end
      OP_CREATE: begin
        res_next_d  = '0;
        res_slice_d = '0;
        if (next_id_q < ID_LIMIT) begin
          id         = next_id_q[IW-1:0];
          wr_addr    = id;
          lvl_we     = 1'b1;
          time_we    = 1'b1;
          if (tail_q[0] != '0) begin
            link_we    = 1'b1;
            link_waddr = tail_q[0];
            link_wdata = id;
          end else begin
            head_d[0] = id;
          end
          tail_d[0] = id;
          next_id_d = next_id_q + 1'b1;
          res_new_d = OUT_ID_W'(id);
          res_st_d  = ST_OK;
        end else begin
          res_new_d = '0;
          res_st_d  = ST_NO_ID;
        end
      end
      OP_START: begin
        started_d  = 1'b1;
        wr_addr    = IW'(1);
        lvl_we     = 1'b1;
        time_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = IW'(1);
        link_wdata = head_q[0];
        if (head_q[0] == '0) begin
          tail_d[0] = IW'(1);
        end
        head_d[0] = IW'(1);
      end
      OP_CHG_WR: begin
        id         = run_head_q;
        wr_addr    = id;
        time_we    = 1'b1;
        time_wdata = aged ? '0 : tsum[AGE_W-1:0];
        nxt        = (id == run_tail_q) ? '0 : link_rd_q;
        run_head_d = nxt;
        if (nxt == '0) begin
          run_tail_d = '0;
        end
        if (!exited_q) begin
          nl = aged ? 2'd0 : lc;
          if (whole_q && !aged && (nl < 2'd2)) begin
            nl = nl + 2'd1;
          end
          lvl_we    = 1'b1;
          lvl_wdata = nl;
          if (tail_q[nl] != '0) begin
            link_we    = 1'b1;
            link_waddr = tail_q[nl];
            link_wdata = id;
          end else begin
            head_d[nl] = id;
          end
          tail_d[nl] = id;
        end
      end
      OP_RF_INIT: begin
        cur_d   = head_q;
        n_d[0]  = '0;
        n_d[1]  = '0;
        n_d[2]  = '0;
        count_d = '0;
      end
      OP_WALK: begin
        rd_addr = cur_q[wl];
        case (cmd_i.ph)
          PH_2A: begin
            count_d = count_q + COUNT_W'(SLICE_L2);
            n_d[2]  = n_q[2] + 1'b1;
          end
          PH_1A: begin
            count_d = count_q + COUNT_W'(SLICE_L1);
            n_d[1]  = n_q[1] + 1'b1;
          end
          PH_0: begin
            count_d = count_q + COUNT_W'(SLICE_L0);
            n_d[0]  = n_q[0] + 1'b1;
          end
          PH_1B: begin
            if (count_q + COUNT_W'(SLICE_L1) <= budget_x) begin
              count_d = count_q + COUNT_W'(SLICE_L1);
              n_d[1]  = n_q[1] + 1'b1;
            end
          end
          default: begin
            if (count_q + COUNT_W'(SLICE_L2) <= budget_x) begin
              count_d = count_q + COUNT_W'(SLICE_L2);
              n_d[2]  = n_q[2] + 1'b1;
            end
          end
        endcase
      end
      OP_WALK_NX: begin
        cur_d[wl] = (cur_q[wl] == tail_q[wl]) ? '0 : link_rd_q;
      end
      OP_MOVE: begin
        id      = head_q[ml];
        rd_addr = id;
        if (run_tail_q != '0) begin
          link_we    = 1'b1;
          link_waddr = run_tail_q;
          link_wdata = id;
        end else begin
          run_head_d = id;
        end
        run_tail_d = id;
        n_d[ml]    = n_q[ml] - 1'b1;
      end
      OP_MOVE_NX: begin
        id         = head_q[ml];
        nxt        = (id == tail_q[ml]) ? '0 : link_rd_q;
        head_d[ml] = nxt;
        if (nxt == '0) begin
          tail_d[ml] = '0;
        end
      end
      OP_OUT_WR: begin
        res_new_d = '0;
        if (run_head_q != '0) begin
          res_next_d  = OUT_ID_W'(run_head_q);
          res_slice_d = charge_of(lc);
          res_st_d    = ST_OK;
        end else begin
          res_next_d  = '0;
          res_slice_d = '0;
          res_st_d    = ST_EMPTY;
        end
      end
      OP_EMIT: begin
        out_next_d  = res_next_q;
        out_new_d   = res_new_q;
        out_slice_d = res_slice_q;
        out_st_d    = res_st_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (lvl_we) begin
      lvl_mem[wr_addr] <= lvl_wdata;
    end
    if (time_we) begin
      time_mem[wr_addr] <= time_wdata;
    end
    link_rd_q <= link_mem[rd_addr];
    lvl_rd_q  <= lvl_mem[rd_addr];
    time_rd_q <= time_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RESET;
      age_q    <= AGE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROUND_BUDGET: budget_q <= cfg_data_i[BUDGET_W-1:0];
        CFG_AGE_LIMIT:    age_q    <= cfg_data_i[AGE_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      next_id_q  <= (IW+1)'(2);
      run_head_q <= '0;
      run_tail_q <= '0;
      for (int i = 0; i < 3; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      started_q  <= started_d;
      next_id_q  <= next_id_d;
      run_head_q <= run_head_d;
      run_tail_q <= run_tail_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    n_q         <= n_d;
    count_q     <= count_d;
    mode_q      <= mode_d;
    whole_q     <= whole_d;
    exited_q    <= exited_d;
    res_next_q  <= res_next_d;
    res_new_q   <= res_new_d;
    res_slice_q <= res_slice_d;
    res_st_q    <= res_st_d;
    out_next_q  <= out_next_d;
    out_new_q   <= out_new_d;
    out_slice_q <= out_slice_d;
    out_st_q    <= out_st_d;
  end

  assign next_thread_o = out_next_q;
  assign new_thread_o  = out_new_q;
  assign slice_ms_o    = out_slice_q;
  assign status_o      = out_st_q;

endmodule

FILE: design/three_level_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// Three-level feedback scheduler
// Creates thread ids and picks the next thread to run from three feedback
// levels, refilling a running queue within a configurable slice budget.
// ----------------------------------------------------------------------------
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   input    | in_valid_i / in_ready_o    | mode_i, whole_slice_i, exited_i
//   result   | out_valid_o / out_ready_i  | next_thread_o, slice_ms_o,
//            |                            | new_thread_o, status_o
//   config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// A create beat passes dispatch and create before its result. A schedule beat
// that leaves the running queue populated charges its thread and reads the
// result; one that refills it also walks the level lists and moves threads,
// each step being one read of the thread link memory (with no thread charged
// first when the running queue was empty, and a start on the very first
// schedule beat). One beat is worked on at a time; the next is accepted as
// soon as the result has gone to the output register, even while that result
// still waits for out_ready_i.
// Reset is asynchronous and clears all queues; the per-thread memories need
// no clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler #(
  parameter int unsigned MAX_THREADS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tfs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic                              whole_slice_i,
  input  logic                              exited_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tfs_pkg::OUT_ID_W-1:0]      next_thread_o,
  output logic [tfs_pkg::SLICE_W-1:0]       slice_ms_o,
  output logic [tfs_pkg::OUT_ID_W-1:0]      new_thread_o,
  output logic [tfs_pkg::STATUS_W-1:0]      status_o
);
  import tfs_pkg::*;

  // The controller only sequences; every queue and memory update lives in
  // the datapath and is selected by the command it is given each cycle.
  dp_cmd_t cmd;
  dp_sts_t sts;

  tfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Queues are singly linked lists through the link memory. The last entry
  // of a list is recognised by comparing with its tail pointer, so a link
  // never has to be cleared when a thread is appended.
  tfs_datapath #(
    .MAX_THREADS (MAX_THREADS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .whole_slice_i (whole_slice_i),
    .exited_i      (exited_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .next_thread_o (next_thread_o),
    .slice_ms_o    (slice_ms_o),
    .new_thread_o  (new_thread_o),
    .status_o      (status_o)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Three-level feedback scheduler testbench
// Drives create and schedule beats with random idling on both channels and
// checks every result against a behavioural scheduler model held in the
// bench. The model is written over thread ids, three level queues and the
// running queue. Both registers are swept through several settings.
// ----------------------------------------------------------------------------
module testbench;
  import tfs_pkg::*;

  localparam int NUM_IDS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  // A row of the directed table. Where chk is set the typed values are also
  // compared against the model's own prediction as a sanity cross-check.
  typedef struct packed {
    logic mode;
    logic whole;
    logic ex;
    logic chk;
    logic [OUT_ID_W-1:0] nt;
    logic [SLICE_W-1:0] sl;
    logic [OUT_ID_W-1:0] nw;
    logic [STATUS_W-1:0] st;
  } row_t;

  typedef struct packed {
    logic [OUT_ID_W-1:0] nt;
    logic [SLICE_W-1:0] sl;
    logic [OUT_ID_W-1:0] nw;
    logic [STATUS_W-1:0] st;
  } sched_res_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic mode_i, whole_slice_i, exited_i;
  logic out_valid_o, out_ready_i;
  logic [OUT_ID_W-1:0] next_thread_o, new_thread_o;
  logic [SLICE_W-1:0] slice_ms_o;
  logic [STATUS_W-1:0] status_o;

  three_level_feedback_scheduler u_dut (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scheduler model. Id 0 stands for an empty link, as in the block.
  // --------------------------------------------------------------------------
  int unsigned m_budget, m_age;
  int unsigned m_link[NUM_IDS];
  int unsigned m_lvl[NUM_IDS];
  int unsigned m_time[NUM_IDS];
  int unsigned m_head[3], m_tail[3];
  int unsigned m_run_head, m_run_tail, m_next_id;
  bit m_started;

  sched_res_t pending_results[$];
  int fails, n_beats, n_results, n_empty, n_noid, n_aged;
  bit in_hold;
  int hold_cycles;

  function automatic int unsigned slice_for(int unsigned lvl);
    return lvl >= 2 ? 100 : (lvl == 1 ? 50 : 25);
  endfunction

  function automatic void queue_append(int unsigned lvl, int unsigned id);
    m_link[id] = 0;
    if (m_tail[lvl] == 0) m_head[lvl] = id;
    else m_link[m_tail[lvl]] = id;
    m_tail[lvl] = id;
  endfunction

  function automatic void move_threads(int unsigned lvl, int unsigned n);
    int unsigned id;
    while (n > 0 && m_head[lvl] != 0) begin
      id = m_head[lvl];
      m_head[lvl] = m_link[id];
      if (m_head[lvl] == 0) m_tail[lvl] = 0;
      m_link[id] = 0;
      if (m_run_head == 0) m_run_head = id;
      else m_link[m_run_tail] = id;
      m_run_tail = id;
      n--;
    end
  endfunction

  // Counts what fits in the round budget, then moves level 0 first.
  function automatic void refill_run_queue();
    int unsigned cnt, n0, n1, n2, c0, c1, c2;
    cnt = 0; n0 = 0; n1 = 0; n2 = 0;
    c0 = m_head[0]; c1 = m_head[1]; c2 = m_head[2];
    if (c2 != 0) begin
      cnt += 100; n2 = 1; c2 = m_link[c2];
    end
    while (c1 != 0 && n1 < 2) begin
      cnt += 50; n1++; c1 = m_link[c1];
    end
    while (c0 != 0 && cnt < m_budget) begin
      cnt += 25; n0++; c0 = m_link[c0];
    end
    while (c1 != 0 && cnt < m_budget) begin
      if (cnt + 50 <= m_budget) begin
        cnt += 50; n1++;
      end
      c1 = m_link[c1];
    end
    while (c2 != 0 && cnt < m_budget) begin
      if (cnt + 100 <= m_budget) begin
        cnt += 100; n2++;
      end
      c2 = m_link[c2];
    end
    move_threads(0, n0);
    move_threads(1, n1);
    move_threads(2, n2);
  endfunction

  function automatic sched_res_t schedule_beat(logic mode, logic whole, logic ex);
    sched_res_t r;
    int unsigned id, lvl, t;
    bit aged;
    r = '0;
    if (!mode) begin
      if (m_next_id < NUM_IDS) begin
        id = m_next_id;
        m_lvl[id] = 0; m_time[id] = 0;
        queue_append(0, id);
        m_next_id++;
        r.nw = OUT_ID_W'(id);
      end else r.st = ST_NO_ID;
      return r;
    end
    if (!m_started) begin
      m_started = 1'b1;
      m_lvl[1] = 0; m_time[1] = 0;
      m_link[1] = m_head[0];
      if (m_head[0] == 0) m_tail[0] = 1;
      m_head[0] = 1;
      if (m_run_head == 0) refill_run_queue();
    end else if (m_run_head != 0) begin
      id = m_run_head;
      lvl = m_lvl[id];
      t = m_time[id] + slice_for(lvl);
      aged = 1'b0;
      if (t >= m_age) begin
        lvl = 0; t = 0; aged = 1'b1; n_aged++;
      end
      m_time[id] = t;
      m_run_head = m_link[id];
      if (m_run_head == 0) m_run_tail = 0;
      if (!ex) begin
        if (whole && !aged && lvl < 2) lvl++;
        m_lvl[id] = lvl;
        queue_append(lvl, id);
      end else m_link[id] = 0;
      if (m_run_head == 0) refill_run_queue();
    end else refill_run_queue();
    if (m_run_head != 0) begin
      r.nt = OUT_ID_W'(m_run_head);
      r.sl = SLICE_W'(slice_for(m_lvl[m_run_head]));
    end else r.st = ST_EMPTY;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one beat, preceded by a random gap, payload held until taken.
  // Valid is only dropped when a gap follows, so back-to-back beats keep it
  // high across the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_beat(logic mode, logic whole, logic ex);
    sched_res_t r;
    int gap;
    gap = $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode; whole_slice_i <= whole; exited_i <= ex;
    do @(posedge clk_i); while (!in_ready_o);
    r = schedule_beat(mode, whole, ex);
    pending_results.push_back(r);
    n_beats++;
  endtask

  // Waits for the block to fall idle: valid is dropped, every expected result
  // is awaited, and further idle cycles follow before the caller goes on.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    if (idx == CFG_ROUND_BUDGET) m_budget = val;
    else m_age = val;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, with one long hold-off to fill the block.
  // --------------------------------------------------------------------------
  initial begin
    int w;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (in_hold) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        in_hold = 1'b0;
      end
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      if (w != 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result checker, sampling at the edge where the beat is taken.
  always @(posedge clk_i) begin
    sched_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (status_o == ST_EMPTY) n_empty++;
        if (status_o == ST_NO_ID) n_noid++;
        if (next_thread_o !== e.nt) begin
          $error("next_thread: expected %0d, got %0d", e.nt, next_thread_o); fails++;
        end
        if (slice_ms_o !== e.sl) begin
          $error("slice_ms: expected %0d, got %0d", e.sl, slice_ms_o); fails++;
        end
        if (new_thread_o !== e.nw) begin
          $error("new_thread: expected %0d, got %0d", e.nw, new_thread_o); fails++;
        end
        if (status_o !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status_o); fails++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Directed rows: opening events with values readable at a glance.
  row_t directed[] = '{
    // First schedule with no created threads: thread 1 runs alone.
    '{1'b1, 1'b0, 1'b0, 1'b1, 6'd1, 7'd25, 6'd0, ST_OK},
    '{1'b0, 1'b0, 1'b0, 1'b1, 6'd0, 7'd0, 6'd2, ST_OK},
    '{1'b0, 1'b1, 1'b1, 1'b1, 6'd0, 7'd0, 6'd3, ST_OK},
    '{1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    '{1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    '{1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    '{1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    '{1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    '{1'b1, 1'b0, 1'b1, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    '{1'b1, 1'b1, 1'b1, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    '{1'b1, 1'b0, 1'b1, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    // Every thread gone: the running queue stays empty.
    '{1'b1, 1'b0, 1'b1, 1'b1, 6'd0, 7'd0, 6'd0, ST_EMPTY},
    '{1'b1, 1'b1, 1'b1, 1'b1, 6'd0, 7'd0, 6'd0, ST_EMPTY},
    '{1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK},
    '{1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0, ST_OK}
  };

  initial begin
    sched_res_t p;
    int unsigned budgets[5];
    int unsigned ages[5];
    bit live;
    budgets = '{300, 100, 1000, 175, 450};
    ages = '{375, 511, 100, 200, 300};
    cfg_we_i = 1'b0; cfg_idx_i = CFG_ROUND_BUDGET; cfg_data_i = '0;
    in_valid_i = 1'b0; mode_i = 1'b0; whole_slice_i = 1'b0; exited_i = 1'b0;
    m_budget = BUDGET_RESET; m_age = AGE_RESET;
    m_head = '{0, 0, 0}; m_tail = '{0, 0, 0};
    m_run_head = 0; m_run_tail = 0; m_next_id = 2; m_started = 1'b0;
    foreach (m_link[i]) begin
      m_link[i] = 0; m_lvl[i] = 0; m_time[i] = 0;
    end
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Typed rows are cross-checked with the model's prediction for that beat.
    foreach (directed[i]) begin
      if (directed[i].chk) begin
        p = {directed[i].nt, directed[i].sl, directed[i].nw, directed[i].st};
        send_beat(directed[i].mode, directed[i].whole, directed[i].ex);
        if (pending_results[$] !== p) begin
          $error("table row %0d disagrees with model", i); fails++;
        end
      end else send_beat(directed[i].mode, directed[i].whole, directed[i].ex);
    end
    drain();

    // Random phases, each under another register setting. Schedule events
    // dominate; creates trickle in so the id space runs out along the way.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_ROUND_BUDGET, budgets[ph]);
      write_reg(CFG_AGE_LIMIT, ages[ph]);
      cfg_we_i <= 1'b0;
      if (ph == 2) begin
        hold_cycles = 400;
        in_hold = 1'b1;
      end
      for (int k = 0; k < 120; k++) begin
        live = ($urandom_range(0, 4) != 0);
        send_beat(live, 1'($urandom_range(0, 1)), ($urandom_range(0, 5) == 0));
      end
      drain();
    end

    $display("Sent %0d beats, checked %0d results (%0d empty, %0d out of ids).",
             n_beats, n_results, n_empty, n_noid);
    $display("Five register settings were used, and %0d threads aged back.", n_aged);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tfs_pkg.sv
design/tfs_ctrl.sv
design/tfs_datapath.sv
design/three_level_feedback_scheduler.sv
tb/testbench.sv
